/* hw/rtl/sccp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccp_pkg: shared types and constants
// Widths, codes and controller states for the size class chunk pool.
// ----------------------------------------------------------------------------
package sccp_pkg;

   localparam int NUM_CLASSES   = 20;
   localparam int MIN_SIZE_BITS = 12;
   localparam int NODE_CAPACITY = 256;
   localparam int ADDR_WIDTH    = 48;

   localparam int NODE_W  = $clog2(NODE_CAPACITY);
   localparam int PTR_W   = NODE_W + 1;
   localparam int CLASS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CNT_W   = $clog2(NODE_CAPACITY + 1);

   localparam logic [PTR_W-1:0] EMPTY_MARK = PTR_W'(NODE_CAPACITY);

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_STATS = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FRESH   = 2'd1,
      ST_BADSIZE = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_type;

   typedef struct packed {
      logic done;
   } stat_type;

endpackage

/* hw/rtl/sccp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccp_req_if / sccp_rsp_if: request and response channels
// Valid/ready channels carrying the pool payloads.
// ----------------------------------------------------------------------------
interface sccp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] size;
   logic [47:0] address;
   modport source (output valid, command, size, address, input ready);
   modport sink   (input valid, command, size, address, output ready);
endinterface

interface sccp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [47:0] address_res;
   logic [31:0] chunk_count;
   logic [8:0]  free_count;
   modport source (output valid, status, address_res, chunk_count, free_count,
                   input ready);
   modport sink   (input valid, status, address_res, chunk_count, free_count,
                   output ready);
endinterface

/* hw/rtl/sccp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccp_ram: generic single port RAM
// One address per cycle: optional write plus a registered read of the old word.
// ----------------------------------------------------------------------------
module sccp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

/* hw/rtl/sccp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccp_ctrl: request sequencer
// Load a request, read the node store, execute, then hold the response.
// ----------------------------------------------------------------------------
module sccp_ctrl import sccp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output ctrl_type ctrl
);
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: state_in = S_RESP;
         S_RESP: if (rsp_ready) state_in = req_valid ? S_EXEC : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == S_IDLE) || (state_ff == S_RESP && rsp_ready);
      rsp_valid = (state_ff == S_RESP);
      ctrl.load = req_ready && req_valid;
      ctrl.exec = (state_ff == S_EXEC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

/* hw/rtl/sccp_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccp_dp: free list datapath
// Class tables, node store, size decode and response registers.
// ----------------------------------------------------------------------------
module sccp_dp import sccp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ctrl_type    ctrl,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_size,
   input  logic [47:0] req_address,
   output logic [1:0]  rsp_status,
   output logic [47:0] rsp_address_res,
   output logic [31:0] rsp_chunk_count,
   output logic [8:0]  rsp_free_count
);
   logic [PTR_W-1:0]   head_ff  [NUM_CLASSES];
   logic [31:0]        total_ff [NUM_CLASSES];
   logic [CNT_W-1:0]   free_ff  [NUM_CLASSES];
   logic [PTR_W-1:0]   spare_ff;
   logic [CNT_W-1:0]   used_ff;

   cmd_type            cmd_ff;
   logic [CLASS_W-1:0] cls_ff;
   logic               bad_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic [NODE_W-1:0]  node_ff;

   logic [1:0]  st_ff;
   logic [47:0] ares_ff;
   logic [31:0] cc_ff;
   logic [8:0]  fc_ff;

   // size decode
   logic               pow2;
   logic [5:0]         lg;
   logic               bad_in;
   logic [CLASS_W-1:0] cls_in;
   always_comb begin
      pow2 = (req_size != 32'd0) && ((req_size & (req_size - 32'd1)) == 32'd0);
      lg = 6'd0;
      for (int i = 0; i < 32; i++) begin
         if (req_size[i]) lg = 6'(i);
      end
      bad_in = !pow2 || (int'(lg) < MIN_SIZE_BITS)
               || (int'(lg) - MIN_SIZE_BITS >= NUM_CLASSES)
               || (req_command == CMD_NONE);
      cls_in = CLASS_W'(int'(lg) - MIN_SIZE_BITS);
   end

   // node address for the store read at load time
   logic [PTR_W-1:0] rd_ptr;
   always_comb begin
      if (req_command == CMD_FREE) rd_ptr = spare_ff;
      else                         rd_ptr = head_ff[cls_in];
   end

   // node store
   logic              we;
   logic [NODE_W-1:0] ram_addr;
   logic [ADDR_WIDTH-1:0] na_rd;
   logic [NODE_W-1:0] nl_rd, nl_wr;
   logic [ADDR_WIDTH-1:0] na_wr;

   logic [PTR_W-1:0] head_c;
   logic             spare_ok, fresh_ok;
   logic             ok_pop, ok_push;
   logic [NODE_W-1:0] push_node;
   always_comb begin
      head_c   = head_ff[cls_ff];
      spare_ok = (spare_ff != EMPTY_MARK);
      fresh_ok = (used_ff < CNT_W'(NODE_CAPACITY));
      ok_pop   = ctrl.exec && !bad_ff && cmd_ff == CMD_ALLOC && head_c != EMPTY_MARK;
      ok_push  = ctrl.exec && !bad_ff && cmd_ff == CMD_FREE && (spare_ok || fresh_ok);
      push_node = spare_ok ? spare_ff[NODE_W-1:0] : used_ff[NODE_W-1:0];
      we = ok_pop || ok_push;
      if (ctrl.exec) ram_addr = ok_push ? push_node : node_ff;
      else           ram_addr = rd_ptr[NODE_W-1:0];
      na_wr = ok_push ? addr_ff : na_rd;
      nl_wr = ok_push ? head_c[NODE_W-1:0] : spare_ff[NODE_W-1:0];
   end

   // the link of an empty-marker head is stored as a flag bit beside the index
   logic link_empty_ff;
   logic [PTR_W-1:0] link_val;
   always_comb begin
      link_val = link_empty_ff ? EMPTY_MARK : {1'b0, nl_rd};
   end

   sccp_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(NODE_CAPACITY)) u_addr (
      .clock(clock), .we(we), .addr(ram_addr), .wdata(na_wr), .rdata(na_rd));
   sccp_ram #(.WIDTH(NODE_W + 1), .DEPTH(NODE_CAPACITY)) u_link (
      .clock(clock), .we(we), .addr(ram_addr),
      .wdata({ok_push ? (head_c == EMPTY_MARK) : !spare_ok, nl_wr}),
      .rdata({link_empty_ff, nl_rd}));

   // request capture
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff  <= cmd_type'(req_command);
         cls_ff  <= cls_in;
         bad_ff  <= bad_in;
         addr_ff <= req_address[ADDR_WIDTH-1:0];
         node_ff <= rd_ptr[NODE_W-1:0];
      end
   end

   // class tables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i]  <= EMPTY_MARK;
            total_ff[i] <= 32'd0;
            free_ff[i]  <= '0;
         end
         spare_ff <= EMPTY_MARK;
         used_ff  <= '0;
      end else if (ctrl.exec && !bad_ff) begin
         if (cmd_ff == CMD_ALLOC) begin
            if (head_c == EMPTY_MARK) begin
               if (total_ff[cls_ff] != 32'hFFFF_FFFF)
                  total_ff[cls_ff] <= total_ff[cls_ff] + 32'd1;
            end else begin
               head_ff[cls_ff] <= link_val;
               if (free_ff[cls_ff] != '0) free_ff[cls_ff] <= free_ff[cls_ff] - 1'b1;
               spare_ff <= {1'b0, node_ff};
            end
         end else if (ok_push) begin
            if (spare_ok) spare_ff <= link_val;
            else          used_ff  <= used_ff + 1'b1;
            head_ff[cls_ff] <= {1'b0, push_node};
            if (free_ff[cls_ff] < CNT_W'(NODE_CAPACITY))
               free_ff[cls_ff] <= free_ff[cls_ff] + 1'b1;
         end
      end
   end

   // response
   logic [31:0] tot_new;
   logic [CNT_W-1:0] fr_new;
   always_comb begin
      tot_new = total_ff[cls_ff];
      fr_new  = free_ff[cls_ff];
      if (cmd_ff == CMD_ALLOC) begin
         if (head_c == EMPTY_MARK) begin
            if (tot_new != 32'hFFFF_FFFF) tot_new = tot_new + 32'd1;
         end else if (fr_new != '0) begin
            fr_new = fr_new - 1'b1;
         end
      end else if (ok_push && fr_new < CNT_W'(NODE_CAPACITY)) begin
         fr_new = fr_new + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         if (bad_ff) begin
            st_ff <= ST_BADSIZE; ares_ff <= '0; cc_ff <= '0; fc_ff <= '0;
         end else begin
            cc_ff <= tot_new;
            fc_ff <= 9'(fr_new);
            ares_ff <= '0;
            if (cmd_ff == CMD_ALLOC) begin
               st_ff <= (head_c == EMPTY_MARK) ? ST_FRESH : ST_OK;
               if (head_c != EMPTY_MARK) ares_ff <= 48'(na_rd);
            end else if (cmd_ff == CMD_FREE && !ok_push) begin
               st_ff <= ST_FULL;
            end else begin
               st_ff <= ST_OK;
            end
         end
      end
   end

   assign rsp_status      = st_ff;
   assign rsp_address_res = ares_ff;
   assign rsp_chunk_count = cc_ff;
   assign rsp_free_count  = fc_ff;
endmodule

/* hw/rtl/size_class_chunk_pool.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_chunk_pool: segregated power of two free list allocator
// Flow: after the accepting edge the sequencer passes through S_EXEC, then
//   holds the response valid in S_RESP until it is taken. A new request is
//   taken only in S_IDLE or as the response is taken, set by the node store
//   read at load followed by its read-modify-write of the node link.
// Reset: synchronous; all class lists empty, counters zero, node store
//   contents undefined and never used before written.
// ----------------------------------------------------------------------------
module size_class_chunk_pool import sccp_pkg::*; (
   input logic          clock,
   input logic          reset,
   sccp_req_if.sink     req,
   sccp_rsp_if.source   rsp
);
   ctrl_type ctrl;

   // sequence each request: capture, then execute against the lists
   sccp_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .ctrl(ctrl));

   // hold class tables, node store and the response registers
   sccp_dp u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl),
      .req_command(req.command), .req_size(req.size), .req_address(req.address),
      .rsp_status(rsp.status), .rsp_address_res(rsp.address_res),
      .rsp_chunk_count(rsp.chunk_count), .rsp_free_count(rsp.free_count));
endmodule

/* hw/rtl/sccp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccp_checker: port level checks
// Watches the channel ports of the pool over time.
// ----------------------------------------------------------------------------
module sccp_checker import sccp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [47:0] rsp_address_res
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");
   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid ##1 rsp_valid)
      else $error("response timing wrong");
   a_ares_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_address_res == 48'd0)
      else $error("address on non ok response");
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");
endmodule

bind size_class_chunk_pool sccp_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_address_res(rsp.address_res));
